@@ src/bts_pkg.sv @@
// Package for the bilinear texture sampler: codes, widths and small helpers.
// Used by bilinear_texture_sampler; no dependencies.
`default_nettype none
package bts_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int TEXEL_BITS = 16;
  localparam int CFG_W      = 9;
  localparam int COL_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = COL_W + 1;
  localparam int XW         = 16 + SIDE_W + 1;
  localparam int ADDR_W     = 16;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_GRAD   = 2'd3;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_GRAD   = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0] col;
    logic [1:0] row;
  } rd_sel_t;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] cfg);
    logic [SIDE_W-1:0] s;
    if (cfg == '0) s = SIDE_W'(1);
    else if (32'(cfg) > MAX_SIDE) s = SIDE_W'(MAX_SIDE);
    else s = SIDE_W'(cfg);
    return s;
  endfunction

  function automatic logic [COL_W-1:0] wrap_inc(input logic [COL_W-1:0] c,
                                                input logic [SIDE_W-1:0] side);
    logic [SIDE_W-1:0] n;
    n = {1'b0, c} + SIDE_W'(1);
    return (n == side) ? '0 : n[COL_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] wrap_dec(input logic [COL_W-1:0] c,
                                                input logic [SIDE_W-1:0] side);
    logic [SIDE_W-1:0] m;
    m = side - SIDE_W'(1);
    return (c == '0) ? m[COL_W-1:0] : c - COL_W'(1);
  endfunction

  // texel fetch order; sample uses the first four, gradient all eight
  function automatic rd_sel_t read_sel(input logic grad, input logic [2:0] j);
    rd_sel_t s;
    if (!grad) begin
      s.col = {1'b0, j[0]};
      s.row = {1'b0, j[1]};
    end else begin
      case (j)
        3'd0: s = '{col: 2'd3, row: 2'd0};
        3'd1: s = '{col: 2'd2, row: 2'd0};
        3'd2: s = '{col: 2'd3, row: 2'd1};
        3'd3: s = '{col: 2'd2, row: 2'd1};
        3'd4: s = '{col: 2'd0, row: 2'd3};
        3'd5: s = '{col: 2'd0, row: 2'd2};
        3'd6: s = '{col: 2'd1, row: 2'd3};
        default: s = '{col: 2'd1, row: 2'd2};
      endcase
    end
    return s;
  endfunction

  function automatic logic signed [33:0] texel_diff(input logic [TEXEL_BITS-1:0] a,
                                                    input logic [TEXEL_BITS-1:0] b);
    logic signed [TEXEL_BITS:0] d;
    d = signed'({1'b0, a}) - signed'({1'b0, b});
    return 34'(d);
  endfunction

endpackage
`default_nettype wire

@@ src/bilinear_texture_sampler.sv @@
// Bilinear texture sampler top level: texel store, sequencer, shared multiplier.
// Depends on bts_pkg.
//
// Single-channel texture unit with a 64K x 16 texel store and repeat wrap.
// Write words give no result and do not raise in_stall; a texel read passes
// through the store's read register and then the output registers. Sample and
// gradient words share one 34x18 multiplier for every product in turn (coordinate
// scaling, row offsets, weights) and the single-port store gives one texel per
// cycle, eight fetches per word. in_stall stays high from acceptance until the
// result word has been taken. The texel store has no reset; read only written texels.
`default_nettype none
module bilinear_texture_sampler
  import bts_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [1:0]            in_opcode,
  input  wire  [15:0]           in_texel_index,
  input  wire  [15:0]           in_texel_value,
  input  wire  signed [31:0]    in_coord_u,
  input  wire  signed [31:0]    in_coord_v,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [15:0]           out_sample_value,
  output logic signed [31:0]    out_grad_u,
  output logic signed [31:0]    out_grad_v,
  output logic [1:0]            out_result_kind,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;
  localparam logic [4:0] STEP_LAST = 5'd24;
  localparam logic [15:0] HALF = 16'h8000;

  logic [CFG_W-1:0] map_width_r, map_height_r;
  logic [1:0]  state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [15:0] fu_r, fu_nxt, fv_r, fv_nxt;
  logic [SIDE_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [15:0] frs_r, frs_nxt, frt_r, frt_nxt;
  logic [COL_W-1:0] cols_r [4];
  logic [COL_W-1:0] cols_nxt [4];
  logic [COL_W-1:0] rows_r [4];
  logic [COL_W-1:0] rows_nxt [4];
  logic [ADDR_W-1:0] rb_r [4];
  logic [ADDR_W-1:0] rb_nxt [4];
  logic [TEXEL_BITS-1:0] tex_r [8];
  logic [TEXEL_BITS-1:0] tex_nxt [8];
  logic signed [51:0] prod_r, acc_r, acc_nxt;
  logic signed [33:0] save_r, save_nxt;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_sample_r, out_sample_nxt;
  logic signed [31:0] out_gu_r, out_gu_nxt, out_gv_r, out_gv_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;

  logic [TEXEL_BITS-1:0] mem [1 << ADDR_W];
  logic [TEXEL_BITS-1:0] mem_rdata_r;
  logic        mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;

  logic        is_grad;
  logic signed [XW-1:0] x;
  logic signed [SIDE_W:0] ci;
  logic [COL_W-1:0] c0, c0_inc;
  logic [4:0]  k_m3, k_m4, k_m8, k_m9;
  rd_sel_t     sel;
  logic [16:0] ids, idt;
  logic signed [51:0] rnd_smp, rnd_grd;
  logic        cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_comb begin
    case (paddr[2])
      REG_WIDTH: prdata = 32'(map_width_r);
      default:   prdata = 32'(map_height_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= CFG_W'(256);
      map_height_r <= CFG_W'(256);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) map_width_r <= pwdata[CFG_W-1:0];
      else map_height_r <= pwdata[CFG_W-1:0];
    end
  end

  // texel store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= in_texel_value;
    if (mem_re) mem_rdata_r <= mem[mem_addr];
  end

  assign is_grad = (op_r == OP_GRAD);
  assign ids     = 17'h10000 - {1'b0, frs_r};
  assign idt     = 17'h10000 - {1'b0, frt_r};
  assign rnd_smp = acc_r + 52'sd2147483648;
  // |prod| < 2^41 here, so the rounded gradient always fits in 32 bits
  assign rnd_grd = prod_r + 52'sd32768;
  assign k_m3    = step_r - 5'd3;
  assign k_m4    = step_r - 5'd4;
  assign k_m8    = step_r - 5'd8;
  assign k_m9    = step_r - 5'd9;
  assign sel     = read_sel(is_grad, k_m8[2:0]);

  // integer part of the scaled coordinate is already reduced modulo the side
  always_comb begin
    x  = signed'({1'b0, prod_r[XW-2:0]}) - ((op_r == OP_SAMPLE) ? XW'(32768) : XW'(0));
    ci = x[XW-1:16];
    c0 = ci[COL_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    op_nxt    = op_r;
    fu_nxt    = fu_r;
    fv_nxt    = fv_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    frs_nxt   = frs_r;
    frt_nxt   = frt_r;
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    rb_nxt    = rb_r;
    tex_nxt   = tex_r;
    acc_nxt   = acc_r;
    save_nxt  = save_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_gu_nxt     = out_gu_r;
    out_gv_nxt     = out_gv_r;
    out_kind_nxt   = out_kind_r;
    mul_a    = '0;
    mul_b    = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = in_texel_index;
    c0_inc   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt = in_opcode;
          fu_nxt = in_coord_u[15:0];
          fv_nxt = in_coord_v[15:0];
          w_nxt  = eff_side(map_width_r);
          h_nxt  = eff_side(map_height_r);
          step_nxt = '0;
          case (in_opcode)
            OP_WRITE: mem_we = 1'b1;
            OP_READ: begin
              mem_re    = 1'b1;
              state_nxt = ST_READ;
            end
            default: state_nxt = ST_RUN;
          endcase
        end
      end

      ST_READ: begin
        out_sample_nxt = mem_rdata_r;
        out_gu_nxt     = '0;
        out_gv_nxt     = '0;
        out_kind_nxt   = KIND_READ;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_OUT;
      end

      ST_RUN: begin
        step_nxt = step_r + 5'd1;
        case (step_r)
          5'd0: begin
            mul_a = 34'(fu_r);
            mul_b = 18'(w_r);
          end
          5'd1: begin
            frs_nxt = x[15:0];
            if (!is_grad) begin
              c0_inc = wrap_inc(ci[SIDE_W] ? wrap_dec('0, w_r) : c0, w_r);
              cols_nxt[0] = ci[SIDE_W] ? wrap_dec('0, w_r) : c0;
              cols_nxt[1] = c0_inc;
              cols_nxt[2] = cols_nxt[0];
              cols_nxt[3] = c0_inc;
            end else begin
              c0_inc = wrap_inc(c0, w_r);
              cols_nxt[0] = c0;
              cols_nxt[1] = c0_inc;
              cols_nxt[2] = (x[15:0] < HALF) ? wrap_dec(c0, w_r) : c0;
              cols_nxt[3] = (x[15:0] < HALF) ? c0 : c0_inc;
            end
            mul_a = 34'(fv_r);
            mul_b = 18'(h_r);
          end
          5'd2: begin
            frt_nxt = x[15:0];
            if (!is_grad) begin
              c0_inc = wrap_inc(ci[SIDE_W] ? wrap_dec('0, h_r) : c0, h_r);
              rows_nxt[0] = ci[SIDE_W] ? wrap_dec('0, h_r) : c0;
              rows_nxt[1] = c0_inc;
              rows_nxt[2] = rows_nxt[0];
              rows_nxt[3] = c0_inc;
            end else begin
              c0_inc = wrap_inc(c0, h_r);
              rows_nxt[0] = c0;
              rows_nxt[1] = c0_inc;
              rows_nxt[2] = (x[15:0] < HALF) ? wrap_dec(c0, h_r) : c0;
              rows_nxt[3] = (x[15:0] < HALF) ? c0 : c0_inc;
            end
          end
          5'd17: begin
            mul_a = is_grad ? texel_diff(tex_r[0], tex_r[1]) : 34'(tex_r[0]);
            mul_b = is_grad ? 18'(idt) : 18'(ids);
          end
          5'd18: begin
            acc_nxt = prod_r;
            mul_a = is_grad ? texel_diff(tex_r[2], tex_r[3]) : 34'(tex_r[1]);
            mul_b = is_grad ? 18'(frt_r) : 18'(frs_r);
          end
          5'd19: begin
            acc_nxt = acc_r + prod_r;
            mul_a = is_grad ? texel_diff(tex_r[4], tex_r[5]) : 34'(tex_r[2]);
            mul_b = 18'(ids);
          end
          5'd20: begin
            save_nxt = acc_r[33:0];
            acc_nxt  = prod_r;
            mul_a = is_grad ? texel_diff(tex_r[6], tex_r[7]) : 34'(tex_r[3]);
            mul_b = 18'(frs_r);
          end
          5'd21: begin
            acc_nxt = acc_r + prod_r;
            mul_a = save_r;
            mul_b = is_grad ? 18'(w_r) : 18'(idt);
          end
          5'd22: begin
            if (is_grad) out_gu_nxt = rnd_grd[47:16];
            else acc_nxt = prod_r;
            mul_a = acc_r[33:0];
            mul_b = is_grad ? 18'(h_r) : 18'(frt_r);
          end
          5'd23: begin
            if (is_grad) out_gv_nxt = rnd_grd[47:16];
            else acc_nxt = acc_r + prod_r;
          end
          STEP_LAST: begin
            if (is_grad) begin
              out_sample_nxt = '0;
              out_kind_nxt   = KIND_GRAD;
            end else begin
              out_sample_nxt = rnd_smp[47:32];
              out_gu_nxt     = '0;
              out_gv_nxt     = '0;
              out_kind_nxt   = KIND_SAMPLE;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = ST_OUT;
          end
          default: begin
            // row offsets: row * width
            if (step_r >= 5'd3 && step_r <= 5'd6) begin
              mul_a = 34'(rows_r[k_m3[1:0]]);
              mul_b = 18'(w_r);
            end
            if (step_r >= 5'd4 && step_r <= 5'd7)
              rb_nxt[k_m4[1:0]] = prod_r[ADDR_W-1:0];
            // texel fetches; the read data is registered and picked up by the following step
            if (step_r >= 5'd8 && step_r <= 5'd15) begin
              mem_re   = 1'b1;
              mem_addr = rb_r[sel.row] + ADDR_W'(cols_r[sel.col]);
            end
            if (step_r >= 5'd9 && step_r <= 5'd16)
              tex_nxt[k_m9[2:0]] = mem_rdata_r;
          end
        endcase
      end

      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    fu_r   <= fu_nxt;
    fv_r   <= fv_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    frs_r  <= frs_nxt;
    frt_r  <= frt_nxt;
    cols_r <= cols_nxt;
    rows_r <= rows_nxt;
    rb_r   <= rb_nxt;
    tex_r  <= tex_nxt;
    acc_r  <= acc_nxt;
    save_r <= save_nxt;
    prod_r <= 52'(mul_a * mul_b);
    out_sample_r <= out_sample_nxt;
    out_gu_r     <= out_gu_nxt;
    out_gv_r     <= out_gv_nxt;
    out_kind_r   <= out_kind_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_grad_u       = out_gu_r;
  assign out_grad_v       = out_gv_r;
  assign out_result_kind  = out_kind_r;

  a_no_take_with_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result word is pending");

  a_grad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_GRAD |-> out_sample_value == '0)
    else $error("gradient word carries a sample value");

  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_GRAD |-> out_grad_u == '0 && out_grad_v == '0)
    else $error("read or sample word carries gradients");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> step_r <= STEP_LAST)
    else $error("sequencer step out of range");

  a_run_ends_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && step_r == STEP_LAST |=> out_valid)
    else $error("sequence finished without a result word");

endmodule
`default_nettype wire
